@@ rtl/bump_arena_allocator_unit_macros.svh @@
// Assertion macros shared by the bump arena allocator RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the including module.
`ifndef BUMP_ARENA_ALLOCATOR_UNIT_MACROS_SVH
`define BUMP_ARENA_ALLOCATOR_UNIT_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define BAA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checks that a property holds in the cycle after a trigger.
`define BAA_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

@@ rtl/baa_pkg.sv @@
// Package for the bump arena allocator: sizes, codes and the structs passed between modules.
// No dependencies.
package baa_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int DATA_W     = 21;
  localparam int BLK_W      = 4;
  localparam int ALIGN      = 8;

  localparam logic [DATA_W-1:0] SIZE_LIMIT         = DATA_W'(1048576);
  localparam logic [DATA_W-1:0] DEFAULT_BLOCK_SIZE = DATA_W'(256);
  localparam logic [DATA_W-1:0] ALIGN_ADD          = DATA_W'(ALIGN - 1);
  localparam logic [DATA_W-1:0] ALIGN_MASK         = ~ALIGN_ADD;
  localparam logic [DATA_W-1:0] MIN_ALLOC          = DATA_W'(ALIGN);

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_MARK   = 2'd1,
    CMD_REWIND = 2'd2,
    CMD_RESET  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TABLE_FULL = 2'd1,
    ST_BAD_MARK   = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t              command;
    logic [DATA_W-1:0] size;
    logic              mark_valid;
    logic [BLK_W-1:0]  mark_block;
    logic [DATA_W-1:0] mark_used;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [BLK_W-1:0]  block_index;
    logic [DATA_W-1:0] offset;
    logic              mark_is_valid;
  } out_item_t;

  // Lookup broadcast to every cell.
  typedef struct packed {
    logic [DATA_W-1:0] n;
    logic [IDX_W-1:0]  cur;
    logic [CNT_W-1:0]  count;
  } baa_query_t;

  // Result passed from cell to cell along the row.
  typedef struct packed {
    logic              fit;
    logic              found;
    logic [IDX_W-1:0]  pick;
    logic [DATA_W-1:0] cur_fill;
  } baa_link_t;

  // Table update broadcast to every cell.
  typedef struct packed {
    logic              en;
    logic              wr_fill;
    logic              wr_cap;
    logic [IDX_W-1:0]  wr_idx;
    logic [DATA_W-1:0] fill_val;
    logic [DATA_W-1:0] cap_val;
    logic              clr;
    logic [CNT_W-1:0]  clr_from;
  } baa_update_t;

endpackage

@@ rtl/baa_cell.sv @@
// One block entry of the arena: capacity and fill, with its stage of the search chain.
// Depends on baa_pkg.
module baa_cell import baa_pkg::*; (
  input  logic              clk,
  input  logic [IDX_W-1:0]  cell_idx,
  input  baa_query_t        qry,
  input  baa_update_t       upd,
  input  baa_link_t         link_in,
  output baa_link_t         link_out
);

  logic [DATA_W-1:0] cap_r, cap_nxt;
  logic [DATA_W-1:0] fill_r, fill_nxt;
  logic [DATA_W:0]   sum;
  logic              is_cur;
  logic              live;
  logic              fits;
  logic              cand;

  assign is_cur = (cell_idx == qry.cur);
  assign sum    = {1'b0, fill_r} + {1'b0, qry.n};
  assign fits   = is_cur && (sum <= {1'b0, cap_r});
  assign live   = (CNT_W'(cell_idx) < qry.count);
  assign cand   = live && (cell_idx > qry.cur) && (cap_r >= qry.n);

  always_comb begin
    link_out.fit      = link_in.fit | fits;
    link_out.found    = link_in.found | cand;
    link_out.pick     = (cand && !link_in.found) ? cell_idx : link_in.pick;
    link_out.cur_fill = is_cur ? fill_r : link_in.cur_fill;
  end

  always_comb begin
    fill_nxt = fill_r;
    cap_nxt  = cap_r;
    if (upd.en) begin
      if (upd.clr && (CNT_W'(cell_idx) >= upd.clr_from)) begin
        fill_nxt = '0;
      end
      if (upd.wr_fill && (cell_idx == upd.wr_idx)) begin
        fill_nxt = upd.fill_val;
      end
      if (upd.wr_cap && (cell_idx == upd.wr_idx)) begin
        cap_nxt = upd.cap_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    fill_r <= fill_nxt;
    cap_r  <= cap_nxt;
  end

endmodule

@@ rtl/bump_arena_allocator_unit.sv @@
// Top level of the bump arena allocator: control, row of block cells, result register.
// Depends on baa_pkg, baa_cell and bump_arena_allocator_unit_macros.svh.
//
//   channel | ports                               | handshake
//   --------+-------------------------------------+-------------------------
//   input   | in_valid, in_stall, in_data         | valid / stall
//   result  | out_valid, out_stall, out_data      | valid / stall
//   config  | cfg_valid, cfg_ready, cfg_data      | valid / ready, block_size
//
// Each command passes through ST_IDLE, which takes the transfer and rounds the size, and
// ST_EVAL, which evaluates it across the chain of cells and commits the table update.
// ST_EVAL repeats while the result register is full and stalled.
// Synchronous reset empties the table and sets block_size to 256; no clearing pass.
// A finished result may wait in the result register while the next item is taken.
`include "bump_arena_allocator_unit_macros.svh"

module bump_arena_allocator_unit import baa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [DATA_W-1:0] bsize_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  cmd_t              cmd_r;
  logic [DATA_W-1:0] n_r, n_nxt;
  logic              mvalid_r;
  logic [BLK_W-1:0]  mblock_r;
  logic [DATA_W-1:0] mused_r;
  logic              out_valid_r;
  out_item_t         out_data_r, res;
  logic [DATA_W-1:0] size_c, rnd;
  logic              in_acc;
  logic              commit;
  logic              has;
  baa_query_t        qry;
  baa_update_t       upd;
  baa_link_t         link [MAX_BLOCKS+1];

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign commit    = (state_r == ST_EVAL) && (!out_valid_r || !out_stall);

  always_comb begin
    size_c = (in_data.size > SIZE_LIMIT) ? SIZE_LIMIT : in_data.size;
    rnd    = (size_c + ALIGN_ADD) & ALIGN_MASK;
    n_nxt  = (rnd == '0) ? MIN_ALLOC : rnd;
  end

  assign qry.n     = n_r;
  assign qry.cur   = cur_r;
  assign qry.count = count_r;
  assign link[0]   = '0;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    baa_cell u_cell (
      .clk      (clk),
      .cell_idx (IDX_W'(g)),
      .qry      (qry),
      .upd      (upd),
      .link_in  (link[g]),
      .link_out (link[g+1])
    );
  end

  assign has = (count_r != '0) && (CNT_W'(cur_r) < count_r);

  always_comb begin
    upd       = '0;
    res       = '0;
    cur_nxt   = cur_r;
    count_nxt = count_r;
    case (cmd_r)
      CMD_ALLOC: begin
        if (has && link[MAX_BLOCKS].fit) begin
          upd.wr_fill     = 1'b1;
          upd.wr_idx      = cur_r;
          upd.fill_val    = DATA_W'(link[MAX_BLOCKS].cur_fill + n_r);
          res.block_index = BLK_W'(cur_r);
          res.offset      = link[MAX_BLOCKS].cur_fill;
        end else if (has && link[MAX_BLOCKS].found) begin
          upd.wr_fill     = 1'b1;
          upd.wr_idx      = link[MAX_BLOCKS].pick;
          upd.fill_val    = n_r;
          cur_nxt         = link[MAX_BLOCKS].pick;
          res.block_index = BLK_W'(link[MAX_BLOCKS].pick);
        end else if (count_r >= CNT_W'(MAX_BLOCKS)) begin
          res.status = ST_TABLE_FULL;
        end else begin
          upd.wr_fill     = 1'b1;
          upd.wr_cap      = 1'b1;
          upd.wr_idx      = IDX_W'(count_r);
          upd.fill_val    = n_r;
          upd.cap_val     = (n_r > bsize_r) ? n_r : bsize_r;
          count_nxt       = count_r + CNT_W'(1);
          cur_nxt         = IDX_W'(count_r);
          res.block_index = BLK_W'(count_r);
        end
      end
      CMD_MARK: begin
        if (has) begin
          res.block_index   = BLK_W'(cur_r);
          res.offset        = link[MAX_BLOCKS].cur_fill;
          res.mark_is_valid = 1'b1;
        end
      end
      CMD_REWIND: begin
        if (!mvalid_r) begin
          upd.clr = 1'b1;
          cur_nxt = '0;
        end else if (CNT_W'(mblock_r) >= count_r) begin
          res.status = ST_BAD_MARK;
        end else begin
          upd.wr_fill  = 1'b1;
          upd.wr_idx   = IDX_W'(mblock_r);
          upd.fill_val = mused_r;
          upd.clr      = 1'b1;
          upd.clr_from = CNT_W'(mblock_r) + CNT_W'(1);
          cur_nxt      = IDX_W'(mblock_r);
        end
      end
      default: begin
        upd.clr = 1'b1;
        cur_nxt = '0;
      end
    endcase
    upd.en = commit;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bsize_r     <= DEFAULT_BLOCK_SIZE;
      count_r     <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        bsize_r <= cfg_data;
      end
      if (commit) begin
        count_r     <= count_nxt;
        cur_r       <= cur_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_data.command;
      n_r      <= n_nxt;
      mvalid_r <= in_data.mark_valid;
      mblock_r <= in_data.mark_block;
      mused_r  <= in_data.mark_used;
    end
    if (commit) begin
      out_data_r <= res;
    end
  end

  `BAA_ASSERT(a_count_max, count_r <= CNT_W'(MAX_BLOCKS), "block count above table size")
  `BAA_ASSERT(a_cur_live, (count_r != '0) |-> (CNT_W'(cur_r) < count_r), "current block not live")
  `BAA_ASSERT_NEXT(a_accept_eval, in_valid && !in_stall, state_r == ST_EVAL, "no evaluation")
  `BAA_ASSERT(a_out_after_eval, $rose(out_valid_r) |-> $past(state_r == ST_EVAL), "stray result")
  `BAA_ASSERT(a_count_step, ($past(rst_n) && (count_r != $past(count_r))) |-> (count_r == $past(count_r) + CNT_W'(1)), "block count jumped")

endmodule
